>>> sv/dpio_pkg.sv
// ---------------------------------------------------------------------------
// dpio_pkg: shared types and constants of the dual-pin io and pwm controller
// payload structs, register indexes, mode and function codes, decode helpers
// ---------------------------------------------------------------------------
`default_nettype none

package dpio_pkg;

  // register file
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam logic [RegIdxW-1:0] RegPinOneSetup  = 3'd0;
  localparam logic [RegIdxW-1:0] RegPinOnePeriod = 3'd1;
  localparam logic [RegIdxW-1:0] RegPinOneDuty   = 3'd2;
  localparam logic [RegIdxW-1:0] RegPinTwoSetup  = 3'd3;
  localparam logic [RegIdxW-1:0] RegPinTwoPeriod = 3'd4;
  localparam logic [RegIdxW-1:0] RegPinTwoDuty   = 3'd5;

  localparam logic [7:0] SetupReset = 8'h80;

  // access codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;

  // setup byte mode codes
  localparam logic [3:0] ModeInput    = 4'd2;
  localparam logic [3:0] ModePushPull = 4'd3;
  localparam logic [3:0] ModeOpenDrn  = 4'd4;
  localparam logic [3:0] ModePwmPp    = 4'd5;
  localparam logic [3:0] ModePwmOd    = 4'd6;

  // pad function codes
  localparam logic [2:0] FuncAnalog   = 3'd0;
  localparam logic [2:0] FuncInput    = 3'd1;
  localparam logic [2:0] FuncPushPull = 3'd2;
  localparam logic [2:0] FuncOpenDrn  = 3'd3;
  localparam logic [2:0] FuncPwmPp    = 3'd4;
  localparam logic [2:0] FuncPwmOd    = 3'd5;

  // pull codes
  localparam logic [1:0] PullNone = 2'd0;
  localparam logic [1:0] PullDown = 2'd1;
  localparam logic [1:0] PullUp   = 2'd2;

  // wake edge codes
  localparam logic [1:0] WakeNone    = 2'd0;
  localparam logic [1:0] WakeFalling = 2'd1;
  localparam logic [1:0] WakeRising  = 2'd2;

  // reload divider and compare scaling
  localparam int unsigned DivW  = 32;
  localparam int unsigned DvsrW = 16;
  localparam logic [15:0] DutyFull   = 16'hFFFF;
  localparam logic [15:0] CmpDivisor = 16'hFFFE;

  typedef struct packed {
    logic        operation;
    logic        pin_select;
    logic [15:0] write_value;
    logic        pad_level;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_low;
    logic [7:0]  read_high;
    logic [2:0]  pad_function;
    logic [1:0]  pull_select;
    logic [1:0]  wake_edge;
    logic        drive_level;
    logic [3:0]  pwm_prescale;
    logic [15:0] pwm_reload;
    logic [15:0] pwm_compare;
    logic        pwm_running;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic div_start;
    logic latch_reload;
    logic latch_prod;
    logic latch_cmp;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pwm;
    logic div_done;
  } sts_t;

  function automatic logic mode_is_output(input logic [3:0] mode);
    return (mode == ModePushPull) || (mode == ModeOpenDrn);
  endfunction

  function automatic logic mode_is_pwm(input logic [3:0] mode);
    return (mode == ModePwmPp) || (mode == ModePwmOd);
  endfunction

  function automatic logic [2:0] mode_to_func(input logic [3:0] mode);
    logic [2:0] func;
    case (mode)
      ModeInput:    func = FuncInput;
      ModePushPull: func = FuncPushPull;
      ModeOpenDrn:  func = FuncOpenDrn;
      ModePwmPp:    func = FuncPwmPp;
      ModePwmOd:    func = FuncPwmOd;
      default:      func = FuncAnalog;
    endcase
    return func;
  endfunction

endpackage

`default_nettype wire

>>> sv/dpio_div.sv
// ---------------------------------------------------------------------------
// dpio_div: iterative restoring divider
// one quotient bit per cycle, done pulses in the cycle after the last step
// ---------------------------------------------------------------------------
`default_nettype none

module dpio_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire  [dpio_pkg::DivW-1:0]        dividend_i,
  input  wire  [dpio_pkg::DvsrW-1:0]       divisor_i,
  output logic                             done_o,
  output logic [dpio_pkg::DivW-1:0]        quotient_o
);
  import dpio_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);
  localparam logic [CntW-1:0] CntLast = CntW'(DivW - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [DvsrW-1:0]    rem_q, rem_d;
  logic [DvsrW-1:0]    dvsr_q, dvsr_d;
  logic [DvsrW:0]      trial;
  logic [DvsrW:0]      diff;

  // one restoring step
  assign trial = {rem_q, quo_q[DivW-1]};
  assign diff  = trial - {1'b0, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntLast;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      if (!diff[DvsrW]) begin
        rem_d = diff[DvsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[DvsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> sv/dpio_dp.sv
// ---------------------------------------------------------------------------
// dpio_dp: datapath of the dual-pin io and pwm controller
// config registers, pin state, pwm timer arithmetic and the result register
// ---------------------------------------------------------------------------
`default_nettype none

module dpio_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  dpio_pkg::cmd_t                   cmd_i,
  output dpio_pkg::sts_t                   sts_o,
  input  dpio_pkg::in_t                    in_data_i,
  input  wire                              cfg_we_i,
  input  wire  [dpio_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  wire  [dpio_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output logic [dpio_pkg::CfgDataW-1:0]    cfg_rdata_o,
  output dpio_pkg::out_t                   out_data_o
);
  import dpio_pkg::*;

  logic [7:0]  setup_q    [2];
  logic [7:0]  setup_d    [2];
  logic [15:0] period_q   [2];
  logic [15:0] period_d   [2];
  logic [15:0] duty_cfg_q [2];
  logic [15:0] duty_cfg_d [2];
  logic [15:0] duty_lvl_q [2];
  logic [15:0] duty_lvl_d [2];
  logic        out_lvl_q  [2];
  logic        out_lvl_d  [2];

  logic        cfg_pin;
  logic        pin_q;
  logic        pad_q;
  logic [15:0] reload_q;
  logic [31:0] prod_q;
  logic [15:0] cmp_q;
  out_t        out_q;

  logic [7:0]  sel_setup;
  logic [3:0]  sel_mode;
  logic [15:0] sel_period;
  logic [15:0] sel_duty;
  logic        sel_olvl;
  logic        sel_pwm;
  logic        sel_out;
  logic [3:0]  sel_ps;
  logic [16:0] per_inc;
  logic [DivW-1:0]  div_dividend;
  logic [DvsrW-1:0] div_divisor;
  logic             div_done;
  logic [DivW-1:0]  div_quo;
  logic [17:0] cmp_fold;
  logic [15:0] cmp_quo;
  out_t        res;

  // config writes, reconfigure on write, item writes
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      setup_d[p]    = setup_q[p];
      period_d[p]   = period_q[p];
      duty_cfg_d[p] = duty_cfg_q[p];
      duty_lvl_d[p] = duty_lvl_q[p];
      out_lvl_d[p]  = out_lvl_q[p];
    end
    cfg_pin = (cfg_idx_i >= RegPinTwoSetup);
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPinOneSetup:  setup_d[0]    = cfg_wdata_i[7:0];
        RegPinOnePeriod: period_d[0]   = cfg_wdata_i[15:0];
        RegPinOneDuty:   duty_cfg_d[0] = cfg_wdata_i[15:0];
        RegPinTwoSetup:  setup_d[1]    = cfg_wdata_i[7:0];
        RegPinTwoPeriod: period_d[1]   = cfg_wdata_i[15:0];
        RegPinTwoDuty:   duty_cfg_d[1] = cfg_wdata_i[15:0];
        default: ;
      endcase
      if (cfg_idx_i <= RegPinTwoDuty) begin
        if (mode_is_output(setup_d[cfg_pin][3:0])) begin
          out_lvl_d[cfg_pin] = period_d[cfg_pin][0];
        end else if (mode_is_pwm(setup_d[cfg_pin][3:0])) begin
          duty_lvl_d[cfg_pin] = duty_cfg_d[cfg_pin];
        end
      end
    end
    if (cmd_i.load_item && (in_data_i.operation == OpWrite)) begin
      if (mode_is_output(setup_q[in_data_i.pin_select][3:0])) begin
        out_lvl_d[in_data_i.pin_select] = in_data_i.write_value[8];
      end else if (mode_is_pwm(setup_q[in_data_i.pin_select][3:0])) begin
        duty_lvl_d[in_data_i.pin_select] = in_data_i.write_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        setup_q[p]    <= SetupReset;
        period_q[p]   <= '0;
        duty_cfg_q[p] <= '0;
        duty_lvl_q[p] <= '0;
        out_lvl_q[p]  <= 1'b0;
      end
    end else begin
      for (int p = 0; p < 2; p++) begin
        setup_q[p]    <= setup_d[p];
        period_q[p]   <= period_d[p];
        duty_cfg_q[p] <= duty_cfg_d[p];
        duty_lvl_q[p] <= duty_lvl_d[p];
        out_lvl_q[p]  <= out_lvl_d[p];
      end
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx_i)
      RegPinOneSetup:  cfg_rdata_o = {24'd0, setup_q[0]};
      RegPinOnePeriod: cfg_rdata_o = {16'd0, period_q[0]};
      RegPinOneDuty:   cfg_rdata_o = {16'd0, duty_cfg_q[0]};
      RegPinTwoSetup:  cfg_rdata_o = {24'd0, setup_q[1]};
      RegPinTwoPeriod: cfg_rdata_o = {16'd0, period_q[1]};
      RegPinTwoDuty:   cfg_rdata_o = {16'd0, duty_cfg_q[1]};
      default:         cfg_rdata_o = '0;
    endcase
  end

  // selected pin view
  assign sel_setup  = setup_q[pin_q];
  assign sel_mode   = sel_setup[3:0];
  assign sel_period = period_q[pin_q];
  assign sel_duty   = duty_lvl_q[pin_q];
  assign sel_olvl   = out_lvl_q[pin_q];
  assign sel_pwm    = mode_is_pwm(sel_mode);
  assign sel_out    = mode_is_output(sel_mode);
  assign sel_ps     = sel_period[15:12];
  assign per_inc    = {1'b0, sel_period} + 17'd1;

  // divider operands: (period+1)*16 / (prescale+1)
  assign div_dividend = {11'd0, per_inc, 4'd0};
  assign div_divisor  = {11'd0, {1'b0, sel_ps} + 5'd1};

  dpio_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // product / 65534: with p = hi*2^16 + lo, p = hi*65534 + (2*hi + lo); the fold
  // stays below 3*65534 for any duty short of full scale, so two compares finish it
  assign cmp_fold = {1'b0, prod_q[31:16], 1'b0} + {2'b00, prod_q[15:0]};
  assign cmp_quo  = prod_q[31:16]
                  + {15'd0, (cmp_fold >= {2'b00, CmpDivisor})}
                  + {15'd0, (cmp_fold >= {1'b0, CmpDivisor, 1'b0})};

  // item capture and timer arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      pin_q <= in_data_i.pin_select;
      pad_q <= in_data_i.pad_level;
    end
    if (cmd_i.latch_reload) begin
      reload_q <= div_quo[15:0] - 16'd1;
    end
    if (cmd_i.latch_prod) begin
      prod_q <= reload_q * sel_duty;
    end
    if (cmd_i.latch_cmp) begin
      cmp_q <= (sel_duty == DutyFull) ? DutyFull : cmp_quo;
    end
  end

  // result assembly
  always_comb begin
    res              = '0;
    res.pad_function = mode_to_func(sel_mode);
    case (sel_setup[5:4])
      2'b01:   res.pull_select = PullDown;
      2'b10:   res.pull_select = PullUp;
      default: res.pull_select = PullNone;
    endcase
    if (sel_mode == ModeInput) begin
      res.read_low = {7'd0, pad_q};
      if (pin_q && ((sel_period[1:0] == WakeFalling) || (sel_period[1:0] == WakeRising))) begin
        res.wake_edge = sel_period[1:0];
      end
    end else if (sel_out) begin
      res.read_low    = {7'd0, pad_q};
      res.read_high   = {7'd0, sel_olvl};
      res.drive_level = sel_olvl;
    end else if (sel_pwm) begin
      res.read_low     = sel_duty[7:0];
      res.read_high    = sel_duty[15:8];
      res.pwm_running  = 1'b1;
      res.pwm_prescale = sel_ps;
      res.pwm_reload   = reload_q;
      res.pwm_compare  = cmp_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  assign sts_o.is_pwm   = sel_pwm;
  assign sts_o.div_done = div_done;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

>>> sv/dpio_ctrl.sv
// ---------------------------------------------------------------------------
// dpio_ctrl: sequencer of the dual-pin io and pwm controller
// steps one access, through the divider and multiplier for pwm pins, owns the handshakes
// ---------------------------------------------------------------------------
`default_nettype none

module dpio_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  dpio_pkg::sts_t  sts_i,
  output dpio_pkg::cmd_t  cmd_o
);
  import dpio_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StStart  = 3'd1;
  localparam logic [2:0] StReload = 3'd2;
  localparam logic [2:0] StMul    = 3'd3;
  localparam logic [2:0] StCmp    = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StStart;
        end
      end
      StStart: begin
        if (sts_i.is_pwm) begin
          cmd_o.div_start = 1'b1;
          state_d         = StReload;
        end else begin
          state_d = StDone;
        end
      end
      StReload: begin
        if (sts_i.div_done) begin
          cmd_o.latch_reload = 1'b1;
          state_d            = StMul;
        end
      end
      StMul: begin
        cmd_o.latch_prod = 1'b1;
        state_d          = StCmp;
      end
      StCmp: begin
        cmd_o.latch_cmp = 1'b1;
        state_d         = StDone;
      end
      StDone: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/dual_pin_io_pwm_controller.sv
// ---------------------------------------------------------------------------
// dual_pin_io_pwm_controller: two configurable io pins with pwm timer setup
// top level: apb register port, access sequencer and datapath
// ---------------------------------------------------------------------------
// usage
//   config: apb port, six registers at byte addresses 0,4,..,20 (setup,
//   period, duty for pin one, then pin two); writes complete in the access
//   cycle, pready is tied high, reads return the register value
//   in channel: one access beat (read or write of one pin) per valid/ready
//   out channel: one result beat per access, describing the selected pin
//   sequence: after accept a non-pwm access passes the start and done states
//   to out_valid_o; a pwm access also runs one 32-step divider pass for the
//   reload, then the multiply state and the compare scaling state
//   occupancy: one access at a time; a new access is taken while the
//   previous result still waits in the output register
//   reset: all pins analog with the pull bits clear, levels and duty zero
//   stall: a result held by out_ready_i low keeps its data stable; the next
//   access finishes its arithmetic and then waits for the output register
// ---------------------------------------------------------------------------
`default_nettype none

module dual_pin_io_pwm_controller (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // access channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  dpio_pkg::in_t                      in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output dpio_pkg::out_t                     out_data_o,
  // register port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [dpio_pkg::CfgAddrW-1:0]      paddr,
  input  wire  [dpio_pkg::CfgDataW-1:0]      pwdata,
  output logic [dpio_pkg::CfgDataW-1:0]      prdata,
  output logic                               pready
);
  import dpio_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              cfg_we;
  logic [RegIdxW-1:0] cfg_idx;

  // apb decode, write in the access cycle
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CfgAddrW-1:2];

  dpio_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dpio_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (pwdata),
    .cfg_rdata_o (prdata),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sv/dpio_chk.sv
// ---------------------------------------------------------------------------
// dpio_chk: port-level checks of the dual-pin io and pwm controller
// watches the access and result channels, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module dpio_chk (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_ready_o,
  input wire                             out_valid_o,
  input wire                             out_ready_i,
  input dpio_pkg::out_t                  out_data_o
);
  import dpio_pkg::*;

  // one access at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("access accepted while previous one in flight");

  // held result beat keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result beat changed while stalled");

  // timer fields only report in pwm modes
  a_timer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.pwm_running) |->
      (out_data_o.pwm_prescale == '0 && out_data_o.pwm_reload == '0 &&
       out_data_o.pwm_compare == '0))
    else $error("timer fields set outside pwm mode");

  // running flag matches the pad function
  a_run_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pwm_running ==
      ((out_data_o.pad_function == FuncPwmPp) || (out_data_o.pad_function == FuncPwmOd))))
    else $error("pwm running flag disagrees with pad function");

  // wake edge only in input mode
  a_wake_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.wake_edge != WakeNone) |->
      (out_data_o.pad_function == FuncInput))
    else $error("wake edge outside input mode");

endmodule

bind dual_pin_io_pwm_controller dpio_chk u_dpio_chk (.*);

`default_nettype wire
